// ===== src/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// Swizzled texel address package
// Shared types, register indexes, format codes and block arrangement tables.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int MEMORY_BYTES = 4194304;
  localparam int COORD_BITS   = 10;

  localparam int MEM_BITS   = $clog2(MEMORY_BYTES);
  localparam int ADDR_W     = 22;
  localparam int COORD_W    = 10;
  localparam int CUSE_BITS  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int CEXT_W     = 12;
  localparam int FMT_W      = 3;
  localparam int BW_W       = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int PAGE_SHIFT = 13;
  localparam int BLOCK_SHIFT = 8;
  localparam int COLUMN_SHIFT = 6;
  localparam int PROW_W     = CEXT_W - 5;
  localparam int PPR_W      = BW_W - 6;
  localparam int PMUL_W     = PROW_W + PPR_W;
  localparam int PIDX_W     = PMUL_W + 1;
  localparam int SUM_W      = PIDX_W + PAGE_SHIFT + 2;

  localparam logic [FMT_W-1:0] FMT_32 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_24 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_16 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_8  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_4  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SNAPSHOT_BASE = 2'd3;

  localparam logic [4:0] ARR_WIDE [32] = '{
    5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21,
    5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23,
    5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29,
    5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31
  };

  localparam logic [4:0] ARR_TALL [32] = '{
    5'd0,  5'd2,  5'd8,  5'd10,
    5'd1,  5'd3,  5'd9,  5'd11,
    5'd4,  5'd6,  5'd12, 5'd14,
    5'd5,  5'd7,  5'd13, 5'd15,
    5'd16, 5'd18, 5'd24, 5'd26,
    5'd17, 5'd19, 5'd25, 5'd27,
    5'd20, 5'd22, 5'd28, 5'd30,
    5'd21, 5'd23, 5'd29, 5'd31
  };

  typedef struct packed {
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
  } texel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] snapshot_offset;
    logic              upper_nibble;
  } result_t;

  typedef struct packed {
    logic [FMT_W-1:0]  pixel_format;
    logic [ADDR_W-1:0] base_address;
    logic [BW_W-1:0]   buffer_width;
    logic [ADDR_W-1:0] snapshot_base;
  } cfg_t;

endpackage

// ===== src/swizzled_texel_address_top.sv =====
// ----------------------------------------------------------------------------
// Swizzled texel address generator
//
//   Channel   Signals                          Direction   Payload
//   texel     texel_valid, texel_stall, texel  in          texel_x, texel_y
//   addr      addr_valid, addr_stall, addr     out         address, offset, nibble
//   cfg       cfg_valid, cfg_ready             in          cfg_index, cfg_data
//
// One item is accepted per cycle while texel_stall is low.
// The path is an input register, the address logic and a result register.
// Reset clears the valid flags and all configuration registers.
// The input register keeps accepting while a result waits, until both are full.
// Configuration writes complete in the cycle they are offered.
// ----------------------------------------------------------------------------
module swizzled_texel_address_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          texel_valid,
  output logic                          texel_stall,
  input  sta_pkg::texel_t               texel,
  output logic                          addr_valid,
  input  logic                          addr_stall,
  output sta_pkg::result_t              addr,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sta_pkg::ADDR_W-1:0]    cfg_data
);

  sta_pkg::cfg_t    cfg;
  sta_pkg::texel_t  texel_q;
  sta_pkg::result_t result;
  logic             texel_q_valid;
  logic             advance;
  logic             accept;

  sta_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sta_addr_calc u_addr_calc (
    .texel  (texel_q),
    .cfg    (cfg),
    .result (result)
  );

  assign advance     = !addr_valid || !addr_stall;
  assign texel_stall = texel_q_valid && !advance;
  assign accept      = texel_valid && !texel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_q_valid <= 1'b0;
      addr_valid    <= 1'b0;
    end else begin
      if (advance) begin
        addr_valid <= texel_q_valid;
      end
      if (advance || !texel_q_valid) begin
        texel_q_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      texel_q <= texel;
    end
    if (advance && texel_q_valid) begin
      addr <= result;
    end
  end

endmodule

// ===== src/sta_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds pixel format, base address, buffer width and snapshot base.
// ----------------------------------------------------------------------------
module sta_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sta_pkg::ADDR_W-1:0]       cfg_data,
  output sta_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sta_pkg::REG_PIXEL_FORMAT: begin
          cfg.pixel_format <= cfg_data[sta_pkg::FMT_W-1:0];
        end
        sta_pkg::REG_BASE_ADDRESS: begin
          cfg.base_address <= cfg_data;
        end
        sta_pkg::REG_BUFFER_WIDTH: begin
          cfg.buffer_width <= cfg_data[sta_pkg::BW_W-1:0];
        end
        sta_pkg::REG_SNAPSHOT_BASE: begin
          cfg.snapshot_base <= cfg_data;
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

endmodule

// ===== src/sta_addr_calc.sv =====
// ----------------------------------------------------------------------------
// Swizzled address calculation
// Splits a texel coordinate into page, block, column and pixel and forms the
// wrapped byte address, the snapshot offset and the nibble select.
// ----------------------------------------------------------------------------
module sta_addr_calc (
  input  sta_pkg::texel_t  texel,
  input  sta_pkg::cfg_t    cfg,
  output sta_pkg::result_t result
);

  logic [sta_pkg::CEXT_W-1:0] x;
  logic [sta_pkg::CEXT_W-1:0] y;

  assign x = sta_pkg::CEXT_W'(texel.texel_x[sta_pkg::CUSE_BITS-1:0]);
  assign y = sta_pkg::CEXT_W'(texel.texel_y[sta_pkg::CUSE_BITS-1:0]);

  always_comb begin
    logic                         fmt_ok;
    logic [4:0]                   blk;
    logic [1:0]                   col;
    logic [5:0]                   inpage;
    logic                         nib;
    logic [sta_pkg::PROW_W-1:0]   page_row;
    logic [sta_pkg::PROW_W-1:0]   page_col;
    logic [sta_pkg::PPR_W-1:0]    ppr;
    logic [sta_pkg::PMUL_W-1:0]   row_pages;
    logic [sta_pkg::PIDX_W-1:0]   page_idx;
    logic [sta_pkg::SUM_W-1:0]    sum;
    logic [sta_pkg::SUM_W-1:0]    diff;
    logic [sta_pkg::MEM_BITS-1:0] addr;
    logic [sta_pkg::MEM_BITS-1:0] offset;

    fmt_ok   = 1'b1;
    nib      = 1'b0;
    blk      = '0;
    col      = '0;
    inpage   = '0;
    page_row = '0;
    page_col = '0;
    ppr      = '0;
    case (cfg.pixel_format)
      sta_pkg::FMT_32, sta_pkg::FMT_24: begin
        blk      = sta_pkg::ARR_WIDE[{y[4:3], x[5:3]}];
        col      = y[2:1];
        inpage   = {y[0], x[2:0], 2'b00};
        page_row = sta_pkg::PROW_W'(y >> 5);
        page_col = sta_pkg::PROW_W'(x >> 6);
        ppr      = sta_pkg::PPR_W'(cfg.buffer_width >> 6);
      end
      sta_pkg::FMT_16: begin
        blk      = sta_pkg::ARR_TALL[{y[5:3], x[5:4]}];
        col      = y[2:1];
        inpage   = {y[0], x[3:0], 1'b0};
        page_row = sta_pkg::PROW_W'(y >> 6);
        page_col = sta_pkg::PROW_W'(x >> 6);
        ppr      = sta_pkg::PPR_W'(cfg.buffer_width >> 6);
      end
      sta_pkg::FMT_8: begin
        blk      = sta_pkg::ARR_WIDE[{y[5:4], x[6:4]}];
        col      = y[3:2];
        inpage   = {y[1:0], x[3:0]};
        page_row = sta_pkg::PROW_W'(y >> 6);
        page_col = sta_pkg::PROW_W'(x >> 7);
        ppr      = sta_pkg::PPR_W'(cfg.buffer_width >> 7);
      end
      sta_pkg::FMT_4: begin
        blk      = sta_pkg::ARR_TALL[{y[6:4], x[6:5]}];
        col      = y[3:2];
        inpage   = {y[1:0], x[4:1]};
        nib      = x[0];
        page_row = sta_pkg::PROW_W'(y >> 7);
        page_col = sta_pkg::PROW_W'(x >> 7);
        ppr      = sta_pkg::PPR_W'(cfg.buffer_width >> 7);
      end
      default: begin
        fmt_ok = 1'b0;
      end
    endcase

    // A zero buffer width means a single page per row.
    if (cfg.buffer_width == '0) begin
      ppr = sta_pkg::PPR_W'(1);
    end

    row_pages = sta_pkg::PMUL_W'(page_row) * sta_pkg::PMUL_W'(ppr);
    page_idx  = sta_pkg::PIDX_W'(row_pages) + sta_pkg::PIDX_W'(page_col);
    sum = (sta_pkg::SUM_W'(page_idx) << sta_pkg::PAGE_SHIFT)
        + (sta_pkg::SUM_W'(blk) << sta_pkg::BLOCK_SHIFT)
        + (sta_pkg::SUM_W'(col) << sta_pkg::COLUMN_SHIFT)
        + sta_pkg::SUM_W'(inpage)
        + sta_pkg::SUM_W'(cfg.base_address);
    addr   = sum[sta_pkg::MEM_BITS-1:0];
    diff   = sta_pkg::SUM_W'(addr) - sta_pkg::SUM_W'(cfg.snapshot_base);
    offset = diff[sta_pkg::MEM_BITS-1:0];

    if (fmt_ok) begin
      result.byte_address    = sta_pkg::ADDR_W'(sta_pkg::SUM_W'(addr));
      result.snapshot_offset = sta_pkg::ADDR_W'(sta_pkg::SUM_W'(offset));
      result.upper_nibble    = nib;
    end else begin
      result = '0;
    end
  end

endmodule
